/* rtl/process_language_token_scanner_assert.svh */
// Assertion macros for the token scanner.
// Used by the scanner modules; depends on nothing else.
`ifndef PROCESS_LANGUAGE_TOKEN_SCANNER_ASSERT_SVH
`define PROCESS_LANGUAGE_TOKEN_SCANNER_ASSERT_SVH
// clocked implication with reset disable
`define PLTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// clocked next-cycle implication
`define PLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/plts_pkg.sv */
// Package for the token scanner: token kinds, modes, keyword table, result type.
// No dependencies.
package plts_pkg;
    localparam int VALUE_WIDTH  = 64;
    localparam int LENGTH_WIDTH = 16;
    localparam int NUM_KW       = 14;

    localparam logic [5:0] K_END = 6'd0;
    localparam logic [5:0] K_BAD = 6'd1;
    localparam logic [5:0] K_ID  = 6'd2;
    localparam logic [5:0] K_NUM = 6'd3;
    localparam logic [5:0] K_LBRACE = 6'd4;
    localparam logic [5:0] K_RBRACE = 6'd5;
    localparam logic [5:0] K_COMMA  = 6'd6;
    localparam logic [5:0] K_EQ     = 6'd7;
    localparam logic [5:0] K_SEMI   = 6'd8;
    localparam logic [5:0] K_BSL    = 6'd9;
    localparam logic [5:0] K_ARROW  = 6'd10;
    localparam logic [5:0] K_LARROW = 6'd11;
    localparam logic [5:0] K_DMINUS = 6'd12;
    localparam logic [5:0] K_LBRB   = 6'd13;
    localparam logic [5:0] K_LBPIPE = 6'd14;
    localparam logic [5:0] K_LBLB   = 6'd15;
    localparam logic [5:0] K_LBGT   = 6'd16;
    localparam logic [5:0] K_LBRK   = 6'd17;
    localparam logic [5:0] K_RBRB   = 6'd18;
    localparam logic [5:0] K_RBRK   = 6'd19;
    localparam logic [5:0] K_SLBSL  = 6'd20;
    localparam logic [5:0] K_PIPERB = 6'd21;
    localparam logic [5:0] K_PIPE3  = 6'd22;
    localparam logic [5:0] K_PIPE2  = 6'd23;
    localparam logic [5:0] K_PTP    = 6'd24;
    localparam logic [5:0] K_KW0    = 6'd25;

    typedef enum logic [3:0] {
        M_IDLE, M_MINUS, M_MINUS2, M_LBRK, M_RBRK, M_SLASH, M_PIPE, M_PIPE2,
        M_PIPETILDE, M_NUMBER, M_DOLLAR, M_IDENT
    } t_mode;

    typedef struct packed {
        logic [5:0]                    token_kind;
        logic [VALUE_WIDTH-1:0]        number_value;
        logic [31:0]                   start_offset;
        logic [15:0]                   token_length;
        logic [31:0]                   start_line;
        logic [15:0]                   start_column;
        logic                          last_of_run;
    } t_token;

    typedef struct packed {
        logic   first_vld;
        t_token first;
        logic   second_vld;
        t_token second;
    } t_pair;

    // Keyword character at a position, zero past the end.
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [8*10-1:0] s;
        logic [3:0] n;
        unique case (k)
            0:  begin s = {"alias", 40'h0};      n = 4'd5;  end
            1:  begin s = "aparallel" << 8;      n = 4'd9;  end
            2:  begin s = {"event", 40'h0};      n = 4'd5;  end
            3:  begin s = "extchoice" << 8;      n = 4'd9;  end
            4:  begin s = {"hide", 48'h0};       n = 4'd4;  end
            5:  begin s = "intchoice" << 8;      n = 4'd9;  end
            6:  begin s = "interleave";          n = 4'd10; end
            7:  begin s = {"timeout", 24'h0};    n = 4'd7;  end
            8:  begin s = "iparallel" << 8;      n = 4'd9;  end
            9:  begin s = {"prefix", 32'h0};     n = 4'd6;  end
            10: begin s = {"process", 24'h0};    n = 4'd7;  end
            11: begin s = {"rename", 32'h0};     n = 4'd6;  end
            12: begin s = "rextchoice";          n = 4'd10; end
            default: begin s = {"seqcomp", 24'h0}; n = 4'd7; end
        endcase
        if (p >= n) return 8'h00;
        return s[8*(9-int'(p)) +: 8];
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] n;
        n = 4'd0;
        for (int p = 0; p < 10; p++)
            if (kw_char(k, 4'(p)) != 8'h00) n = 4'(p + 1);
        return n;
    endfunction
endpackage

/* rtl/plts_if.sv */
// Valid/ready channel interfaces for the token scanner.
// Depends on plts_pkg.
interface plts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;
    modport source (output valid, in_byte, end_of_input, input ready);
    modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface plts_out_if;
    logic              valid;
    logic              ready;
    plts_pkg::t_token  tok;
    modport source (output valid, tok, input ready);
    modport sink   (input valid, tok, output ready);
endinterface

/* rtl/plts_front.sv */
// Front end: scans one byte per beat and produces up to two tokens.
// Depends on plts_pkg, the input interface and the assertion header.
`include "process_language_token_scanner_assert.svh"
module plts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    plts_in_if.sink            i_in,
    input  logic               i_q_ready,
    output logic               o_q_push,
    output plts_pkg::t_pair    o_pair
);
    localparam logic [plts_pkg::VALUE_WIDTH-1:0] VMAX = '1;
    localparam logic [plts_pkg::LENGTH_WIDTH-1:0] LMAX = '1;

    plts_pkg::t_mode r_mode, n_mode;
    logic [plts_pkg::VALUE_WIDTH-1:0]  r_acc, n_acc;
    logic [plts_pkg::NUM_KW-1:0]       r_cand, n_cand;
    logic [plts_pkg::LENGTH_WIDTH-1:0] r_len, n_len;
    logic [31:0] r_line, n_line, r_off, n_off, r_sline, n_sline, r_soff, n_soff;
    logic [15:0] r_col, n_col, r_scol, n_scol;
    logic        r_cmt, n_cmt;

    logic        fire;
    logic [7:0]  b;
    logic        dig, alp, wrd, spc;
    logic [3:0]  dv;
    logic [plts_pkg::LENGTH_WIDTH-1:0] len2;
    logic        ext, ovf;
    logic [5:0]  done_k;
    logic [plts_pkg::VALUE_WIDTH+3:0] prod;
    plts_pkg::t_pair pr;

    assign i_in.ready = i_q_ready;
    assign fire = i_in.valid && i_in.ready;
    assign b    = i_in.in_byte;
    assign dig  = b >= "0" && b <= "9";
    assign alp  = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    assign wrd  = dig || alp || b == "_";
    assign spc  = b == " " || (b >= 8'd9 && b <= 8'd13);
    assign dv   = b[3:0];
    assign len2 = (r_len != LMAX) ? r_len + 1'b1 : r_len;
    assign prod = {4'd0, r_acc} * 4'd10 + {{plts_pkg::VALUE_WIDTH{1'b0}}, dv};
    assign ovf  = prod[plts_pkg::VALUE_WIDTH+3:plts_pkg::VALUE_WIDTH] != 4'd0;

    function automatic logic [plts_pkg::NUM_KW-1:0] narrow(
        input logic [plts_pkg::NUM_KW-1:0] c, input logic [plts_pkg::LENGTH_WIDTH-1:0] p,
        input logic [7:0] ch);
        logic [plts_pkg::NUM_KW-1:0] r;
        r = c;
        for (int k = 0; k < plts_pkg::NUM_KW; k++)
            if (p >= 10 || plts_pkg::kw_char(k, p[3:0]) != ch) r[k] = 1'b0;
        return r;
    endfunction

    function automatic logic [5:0] id_kind(input logic [plts_pkg::NUM_KW-1:0] c,
                                           input logic [plts_pkg::LENGTH_WIDTH-1:0] l);
        logic [5:0] r;
        r = plts_pkg::K_ID;
        for (int k = plts_pkg::NUM_KW - 1; k >= 0; k--)
            if (l <= 10 && c[k] && plts_pkg::kw_len(k) == l[3:0])
                r = plts_pkg::K_KW0 + 6'(k);
        return r;
    endfunction

    function automatic plts_pkg::t_token mk(input logic [5:0] k,
        input logic [plts_pkg::VALUE_WIDTH-1:0] v, input logic [31:0] o,
        input logic [plts_pkg::LENGTH_WIDTH-1:0] l, input logic [31:0] ln,
        input logic [15:0] c);
        plts_pkg::t_token t;
        t.token_kind   = k;
        t.number_value = v;
        t.start_offset = o;
        t.token_length = 16'(l);
        t.start_line   = ln;
        t.start_column = c;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic [5:0] fk;
        logic [plts_pkg::VALUE_WIDTH-1:0] fv;
        logic [5:0] single;
        n_mode = r_mode; n_acc = r_acc; n_cand = r_cand; n_len = r_len;
        n_line = r_line; n_col = r_col; n_off = r_off; n_sline = r_sline;
        n_scol = r_scol; n_soff = r_soff; n_cmt = r_cmt;
        pr = '0;
        ext = 1'b0; done_k = plts_pkg::K_END; fv = '0; single = plts_pkg::K_END;
        fk = plts_pkg::K_BAD;
        unique case (r_mode)
            plts_pkg::M_MINUS2:  fk = plts_pkg::K_DMINUS;
            plts_pkg::M_LBRK:    fk = plts_pkg::K_LBRK;
            plts_pkg::M_RBRK:    fk = plts_pkg::K_RBRK;
            plts_pkg::M_PIPE2:   fk = plts_pkg::K_PIPE2;
            plts_pkg::M_NUMBER:  begin fk = plts_pkg::K_NUM; fv = r_acc; end
            plts_pkg::M_IDENT:   fk = id_kind(r_cand, r_len);
            default:             fk = plts_pkg::K_BAD;
        endcase
        if (i_in.end_of_input) begin
            if (r_mode != plts_pkg::M_IDLE) begin
                pr.first_vld = 1'b1;
                pr.first = mk(fk, fv, r_soff, r_len, r_sline, r_scol);
                pr.second_vld = 1'b1;
                pr.second = mk(plts_pkg::K_END, '0, r_off, '0, r_line, r_col);
            end else begin
                pr.first_vld = 1'b1;
                pr.first = mk(plts_pkg::K_END, '0, r_off, '0, r_line, r_col);
            end
            n_mode = plts_pkg::M_IDLE;
            n_cmt = 1'b0;
        end else begin
            if (r_cmt) begin
                if (b == 8'd10) n_cmt = 1'b0;
            end else begin
                unique case (r_mode)
                    plts_pkg::M_MINUS:
                        if (b == ">") done_k = plts_pkg::K_ARROW;
                        else if (b == "-") begin
                            ext = 1'b1; n_mode = plts_pkg::M_MINUS2; n_len = len2;
                        end
                    plts_pkg::M_MINUS2: if (b == ">") done_k = plts_pkg::K_LARROW;
                    plts_pkg::M_LBRK:
                        if (b == "]") done_k = plts_pkg::K_LBRB;
                        else if (b == "|") done_k = plts_pkg::K_LBPIPE;
                        else if (b == "[") done_k = plts_pkg::K_LBLB;
                        else if (b == ">") done_k = plts_pkg::K_LBGT;
                    plts_pkg::M_RBRK: if (b == "]") done_k = plts_pkg::K_RBRB;
                    plts_pkg::M_SLASH: if (b == "\\") done_k = plts_pkg::K_SLBSL;
                    plts_pkg::M_PIPE:
                        if (b == "]") done_k = plts_pkg::K_PIPERB;
                        else if (b == "|") begin
                            ext = 1'b1; n_mode = plts_pkg::M_PIPE2; n_len = len2;
                        end else if (b == "~") begin
                            ext = 1'b1; n_mode = plts_pkg::M_PIPETILDE; n_len = len2;
                        end
                    plts_pkg::M_PIPE2: if (b == "|") done_k = plts_pkg::K_PIPE3;
                    plts_pkg::M_PIPETILDE: if (b == "|") done_k = plts_pkg::K_PTP;
                    plts_pkg::M_NUMBER:
                        if (dig) begin
                            ext = 1'b1;
                            if (ovf) begin
                                pr.first_vld = 1'b1;
                                pr.first = mk(plts_pkg::K_BAD, '0, r_soff, len2, r_sline,
                                              r_scol);
                                n_mode = plts_pkg::M_IDLE;
                            end else begin
                                n_acc = prod[plts_pkg::VALUE_WIDTH-1:0];
                                n_len = len2;
                            end
                        end
                    plts_pkg::M_DOLLAR:
                        if (wrd) begin
                            ext = 1'b1; n_mode = plts_pkg::M_IDENT; n_len = len2;
                        end
                    plts_pkg::M_IDENT:
                        if (wrd) begin
                            ext = 1'b1; n_cand = narrow(r_cand, r_len, b); n_len = len2;
                        end
                    default: ;
                endcase
                if (done_k != plts_pkg::K_END) begin
                    ext = 1'b1;
                    pr.first_vld = 1'b1;
                    pr.first = mk(done_k, '0, r_soff, len2, r_sline, r_scol);
                    n_mode = plts_pkg::M_IDLE;
                end
                if (!ext) begin
                    if (r_mode != plts_pkg::M_IDLE) begin
                        pr.first_vld = 1'b1;
                        pr.first = mk(fk, fv, r_soff, r_len, r_sline, r_scol);
                        n_mode = plts_pkg::M_IDLE;
                    end
                    priority if (b == "{") single = plts_pkg::K_LBRACE;
                    else if (b == "}") single = plts_pkg::K_RBRACE;
                    else if (b == ",") single = plts_pkg::K_COMMA;
                    else if (b == "=") single = plts_pkg::K_EQ;
                    else if (b == ";") single = plts_pkg::K_SEMI;
                    else if (b == "\\") single = plts_pkg::K_BSL;
                    else single = plts_pkg::K_END;
                    n_sline = r_line; n_scol = r_col; n_soff = r_off;
                    n_len = plts_pkg::LENGTH_WIDTH'(1);
                    if (spc) begin
                        n_sline = r_sline; n_scol = r_scol; n_soff = r_soff; n_len = r_len;
                    end else if (b == "#") begin
                        n_cmt = 1'b1;
                        n_sline = r_sline; n_scol = r_scol; n_soff = r_soff; n_len = r_len;
                    end else if (b == "-") n_mode = plts_pkg::M_MINUS;
                    else if (b == "[") n_mode = plts_pkg::M_LBRK;
                    else if (b == "]") n_mode = plts_pkg::M_RBRK;
                    else if (b == "/") n_mode = plts_pkg::M_SLASH;
                    else if (b == "|") n_mode = plts_pkg::M_PIPE;
                    else if (b == "$") begin
                        n_mode = plts_pkg::M_DOLLAR; n_cand = '0;
                    end else if (dig) begin
                        n_mode = plts_pkg::M_NUMBER;
                        n_acc = plts_pkg::VALUE_WIDTH'(dv);
                    end else if (alp || b == "_") begin
                        n_mode = plts_pkg::M_IDENT;
                        n_cand = narrow('1, '0, b);
                    end else begin
                        n_sline = r_sline; n_scol = r_scol; n_soff = r_soff; n_len = r_len;
                        if (single == plts_pkg::K_END) single = plts_pkg::K_BAD;
                    end
                    if (single != plts_pkg::K_END) begin
                        if (pr.first_vld) begin
                            pr.second_vld = 1'b1;
                            pr.second = mk(single, '0, r_off, plts_pkg::LENGTH_WIDTH'(1),
                                           r_line, r_col);
                        end else begin
                            pr.first_vld = 1'b1;
                            pr.first = mk(single, '0, r_off, plts_pkg::LENGTH_WIDTH'(1),
                                          r_line, r_col);
                        end
                    end
                end
            end
            if (b == 8'd10) begin
                if (r_line != '1) n_line = r_line + 1'b1;
                n_col = 16'd1;
            end else if (r_col != '1) n_col = r_col + 1'b1;
            if (r_off != '1) n_off = r_off + 1'b1;
        end
        if (pr.second_vld) pr.second.last_of_run = 1'b1;
        else if (pr.first_vld) pr.first.last_of_run = 1'b1;
    end

    assign o_pair   = pr;
    assign o_q_push = fire && pr.first_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= plts_pkg::M_IDLE; r_acc <= '0; r_cand <= '1; r_len <= '0;
            r_line <= 32'd1; r_col <= 16'd1; r_off <= '0; r_sline <= 32'd1;
            r_scol <= 16'd1; r_soff <= '0; r_cmt <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode; r_acc <= n_acc; r_cand <= n_cand; r_len <= n_len;
            r_line <= n_line; r_col <= n_col; r_off <= n_off; r_sline <= n_sline;
            r_scol <= n_scol; r_soff <= n_soff; r_cmt <= n_cmt;
        end
    end

    `PLTS_ASSERT_IMP(a_second_needs_first, i_clk, i_rst_n, pr.second_vld, pr.first_vld)
    `PLTS_ASSERT_NEXT(a_eoi_idle, i_clk, i_rst_n, fire && i_in.end_of_input,
                      r_mode == plts_pkg::M_IDLE && !r_cmt)
    `PLTS_ASSERT_IMP(a_line_nonzero, i_clk, i_rst_n, 1'b1, r_line != 32'd0 && r_col != 16'd0)
endmodule

/* rtl/plts_back.sv */
// Back end: queue of token pairs and serializer onto the output channel.
// Depends on plts_pkg, the output interface and the assertion header.
`include "process_language_token_scanner_assert.svh"
module plts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  plts_pkg::t_pair    i_pair,
    output logic               o_ready,
    plts_out_if.source         o_out
);
    plts_pkg::t_pair r_q [2];
    logic            r_wp, r_rp, r_sub;
    logic [1:0]      r_cnt;
    logic            pop, adv;
    plts_pkg::t_pair head;

    assign head        = r_q[r_rp];
    assign o_out.valid = r_cnt != 2'd0;
    assign o_out.tok   = r_sub ? head.second : head.first;
    assign adv         = o_out.valid && o_out.ready;
    assign pop         = adv && (r_sub || !head.second_vld);
    assign o_ready     = r_cnt != 2'd2 || pop;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_sub <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) begin
                r_rp <= ~r_rp; r_sub <= 1'b0;
            end else if (adv) r_sub <= 1'b1;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    `PLTS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2 && !pop, !i_push)
    `PLTS_ASSERT_IMP(a_sub_valid, i_clk, i_rst_n, r_sub, r_cnt != 2'd0 && head.second_vld)
    `PLTS_ASSERT_IMP(a_last_on_pop, i_clk, i_rst_n, adv, o_out.tok.last_of_run == pop)
endmodule

/* rtl/process_language_token_scanner.sv */
// Token scanner top level: front scanner, pair queue and output serializer.
// A token is written into the registered pair queue when its byte is taken.
// Throughput: one byte per cycle; a byte ending two tokens sends them out in turn.
// The two-entry pair queue sets the rate: input stalls only when it is full.
// Reset (synchronous, active low) clears position to line 1, column 1, offset 0.
module process_language_token_scanner (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plts_in_if.sink      i_in,
    plts_out_if.source   o_out
);
    logic            q_ready, q_push;
    plts_pkg::t_pair pair;

    plts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .i_q_ready(q_ready), .o_q_push(q_push), .o_pair(pair)
    );

    plts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_pair(pair),
        .o_ready(q_ready), .o_out(o_out)
    );
endmodule
